FILE: design/ordered_ring_list_engine_defines.svh
// ----------------------------------------------------------------------------
// ordered ring list engine assertion macros
// shared property wrappers, clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ORDERED_RING_LIST_ENGINE_DEFINES_SVH
`define ORDERED_RING_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define ORLE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ORLE_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/orle_pkg.sv
// ----------------------------------------------------------------------------
// orle_pkg
// sizes, operation and status codes, and controller/datapath bundles
// ----------------------------------------------------------------------------
`default_nettype none

package orle_pkg;

   // storage geometry
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int STS_W    = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

   // result status codes
   localparam logic [STS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STS_W-1:0] STS_EMPTY     = 2'd1;
   localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd2;
   localparam logic [STS_W-1:0] STS_FULL      = 2'd3;

   // commands from controller to datapath
   typedef struct packed {
      logic             load_item;
      logic             ins_first;
      logic             ins_link;
      logic             walk_start;
      logic             walk_step;
      logic             del_commit;
      logic             out_load;
      logic [STS_W-1:0] out_status;
      logic             out_data;
      logic             out_last;
   } orle_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] operation;
      logic            is_empty;
      logic            is_full;
      logic            key_match;
      logic            walk_last;
      logic            out_free;
   } orle_sts_type;

endpackage

`default_nettype wire

FILE: design/orle_if.sv
// ----------------------------------------------------------------------------
// orle channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

// request channel: one word per operation
interface orle_req_if import orle_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic signed [DATA_W-1:0] key;

   modport source (output valid, output operation, output key, input ready);
   modport sink (input valid, input operation, input key, output ready);
endinterface

// response channel: one word per result
interface orle_rsp_if import orle_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STS_W-1:0]         status;
   logic signed [DATA_W-1:0] value;
   logic                     last;

   modport source (output valid, output status, output value, output last, input ready);
   modport sink (input valid, input status, input value, input last, output ready);
endinterface

`default_nettype wire

FILE: design/orle_ram.sv
// ----------------------------------------------------------------------------
// orle_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module orle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/orle_datapath.sv
// ----------------------------------------------------------------------------
// orle_datapath
// entry and link storage, head/tail/count/free state, walk pointers, result word
// ----------------------------------------------------------------------------
`default_nettype none

module orle_datapath import orle_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire orle_cmd_type             cmd,
   output orle_sts_type                  sts,
   input  wire logic [OP_W-1:0]          req_operation,
   input  wire logic signed [DATA_W-1:0] req_key,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [STS_W-1:0]              rsp_status,
   output logic signed [DATA_W-1:0]      rsp_value,
   output logic                          rsp_last
);

   // item latch
   logic [OP_W-1:0]          op_ff;
   logic signed [DATA_W-1:0] key_ff;

   // list state
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CAPACITY-1:0] free_ff, free_in;

   // insert slot and walk pointers
   logic [IDX_W-1:0] slot_ff;
   logic [IDX_W-1:0] cur_ff;
   logic [IDX_W-1:0] prv_ff;
   logic [IDX_W-1:0] step_ff;

   // result word
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STS_W-1:0]         rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic                     rsp_last_ff;

   // ram ports
   logic              val_wr_en;
   logic [DATA_W-1:0] val_rd;
   logic              nxt_wr_en;
   logic [IDX_W-1:0]  nxt_wr_addr;
   logic [IDX_W-1:0]  nxt_wr_data;
   logic [IDX_W-1:0]  nxt_rd;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;

   logic [IDX_W-1:0] free_slot;
   logic             is_empty;
   logic             out_free;

   // lowest free slot
   always_comb begin
      free_slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            free_slot = IDX_W'(i);
         end
      end
   end

   assign is_empty = (count_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // walk read address: head on start, else the link just read
   assign rd_en   = cmd.walk_start || cmd.walk_step;
   assign rd_addr = cmd.walk_start ? head_ff : nxt_rd;

   // value store is written only when a slot is claimed
   assign val_wr_en = cmd.ins_first;

   // link store write selection
   always_comb begin
      nxt_wr_en   = 1'b0;
      nxt_wr_addr = prv_ff;
      nxt_wr_data = nxt_rd;
      if (cmd.ins_first) begin
         nxt_wr_en   = 1'b1;
         nxt_wr_addr = free_slot;
         nxt_wr_data = is_empty ? free_slot : head_ff;
      end else if (cmd.ins_link) begin
         nxt_wr_en   = !is_empty;
         nxt_wr_addr = tail_ff;
         nxt_wr_data = slot_ff;
      end else if (cmd.del_commit) begin
         nxt_wr_en   = 1'b1;
      end
   end

   orle_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (free_slot),
      .wr_data ($unsigned(key_ff)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   orle_ram #(
      .WIDTH (IDX_W),
      .DEPTH (CAPACITY)
   ) u_nxt_ram (
      .clock   (clock),
      .wr_en   (nxt_wr_en),
      .wr_addr (nxt_wr_addr),
      .wr_data (nxt_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (nxt_rd)
   );

   // list state next values
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      free_in  = free_ff;
      if (cmd.ins_link) begin
         if (is_empty) begin
            head_in = slot_ff;
         end
         tail_in          = slot_ff;
         count_in         = count_ff + CNT_W'(1);
         free_in[slot_ff] = 1'b0;
      end else if (cmd.del_commit) begin
         if (cur_ff == head_ff) begin
            head_in = nxt_rd;
         end
         if (cur_ff == tail_ff) begin
            tail_in = prv_ff;
         end
         count_in        = count_ff - CNT_W'(1);
         free_in[cur_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         free_ff  <= '1;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         free_ff  <= free_in;
      end
   end

   // item latch, slot and walk pointers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff  <= req_operation;
         key_ff <= req_key;
      end
      if (cmd.ins_first) begin
         slot_ff <= free_slot;
      end
      if (cmd.walk_start) begin
         cur_ff  <= head_ff;
         prv_ff  <= tail_ff;
         step_ff <= '0;
      end else if (cmd.walk_step) begin
         cur_ff  <= nxt_rd;
         prv_ff  <= cur_ff;
         step_ff <= step_ff + IDX_W'(1);
      end
   end

   // result word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= cmd.out_status;
         rsp_value_ff  <= cmd.out_data ? $signed(val_rd) : '0;
         rsp_last_ff   <= cmd.out_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

   // status to controller
   assign sts.operation = op_ff;
   assign sts.is_empty  = is_empty;
   assign sts.is_full   = (count_ff == CNT_W'(CAPACITY));
   assign sts.key_match = ($unsigned(key_ff) == val_rd);
   assign sts.walk_last = (CNT_W'(step_ff) == (count_ff - CNT_W'(1)));
   assign sts.out_free  = out_free;

endmodule

`default_nettype wire

FILE: design/orle_ctrl.sv
// ----------------------------------------------------------------------------
// orle_ctrl
// operation sequencer: decode, insert link steps, list walk, result issue
// ----------------------------------------------------------------------------
`default_nettype none

module orle_ctrl import orle_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire orle_sts_type sts,
   output orle_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_INS1   = 3'd2;
   localparam logic [2:0] ST_INS2   = 3'd3;
   localparam logic [2:0] ST_WALK   = 3'd4;
   localparam logic [2:0] ST_RESP   = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [STS_W-1:0] resp_status_ff, resp_status_in;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      resp_status_in = resp_status_ff;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.operation)
               OP_INSERT: begin
                  if (sts.is_full) begin
                     resp_status_in = STS_FULL;
                     state_in       = ST_RESP;
                  end else begin
                     state_in = ST_INS1;
                  end
               end
               OP_DELETE, OP_DUMP: begin
                  if (sts.is_empty) begin
                     resp_status_in = STS_EMPTY;
                     state_in       = ST_RESP;
                  end else begin
                     cmd.walk_start = 1'b1;
                     state_in       = ST_WALK;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_INS1: begin
            cmd.ins_first = 1'b1;
            state_in      = ST_INS2;
         end
         ST_INS2: begin
            cmd.ins_link   = 1'b1;
            resp_status_in = STS_OK;
            state_in       = ST_RESP;
         end
         ST_WALK: begin
            if (sts.operation == OP_DUMP) begin
               // one stored value per word, stalls while the result is held
               if (sts.out_free) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_status = STS_OK;
                  cmd.out_data   = 1'b1;
                  cmd.out_last   = sts.walk_last;
                  if (sts.walk_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.walk_step = 1'b1;
                  end
               end
            end else begin
               // search for the first match from the head
               if (sts.key_match) begin
                  cmd.del_commit = 1'b1;
                  resp_status_in = STS_OK;
                  state_in       = ST_RESP;
               end else if (sts.walk_last) begin
                  resp_status_in = STS_NOT_FOUND;
                  state_in       = ST_RESP;
               end else begin
                  cmd.walk_step = 1'b1;
               end
            end
         end
         ST_RESP: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = resp_status_ff;
               cmd.out_last   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         resp_status_ff <= STS_OK;
      end else begin
         state_ff       <= state_in;
         resp_status_ff <= resp_status_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

FILE: design/ordered_ring_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_ring_list_engine
// insert: claim the lowest free slot, then link it at the tail; a full list gives a full word
// delete: the walk reads one link per cycle from the head; an empty list gives an empty word
// dump: count words from the head, one word per cycle while the result word is free
// one operation at a time, the next accept comes once the last word is loaded;
// a held result word stalls the walk; operation code 3 gives no word
// synchronous active-high reset empties the list, no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none
`include "ordered_ring_list_engine_defines.svh"

module ordered_ring_list_engine import orle_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   orle_req_if.sink   req_chan,
   orle_rsp_if.source rsp_chan
);

   orle_cmd_type cmd;
   orle_sts_type sts;
   logic         req_ready;
   logic [2:0]   link_writes;

   // sequencer
   orle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and result word
   orle_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_operation (req_chan.operation),
      .req_key       (req_chan.key),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_status    (rsp_chan.status),
      .rsp_value     (rsp_chan.value),
      .rsp_last      (rsp_chan.last)
   );

   assign req_chan.ready = req_ready;

   // link ram write sources
   assign link_writes = {cmd.ins_first, cmd.ins_link, cmd.del_commit};

   // checks
   `ORLE_ASSERT_IMP(a_out_no_overwrite, cmd.out_load, sts.out_free, "result word overwritten")
   `ORLE_ASSERT_IMP(a_link_one_writer, 1'b1, $onehot0(link_writes), "link ram written twice")
   `ORLE_ASSERT_IMP(a_no_insert_full, cmd.ins_first, !sts.is_full, "insert into full list")
   `ORLE_ASSERT_NXT(a_busy_after_accept, req_chan.valid && req_ready, !req_ready, "accepted while busy")

endmodule

`default_nettype wire
